@@ design/dmpd_pkg.sv @@
// Shared types and constants of the dual magic-word parameter deframer.
package dmpd_pkg;

  localparam int HeaderLenDef = 4;
  localparam int SlowWordsDef = 62;
  localparam int SlowFlagsDef = 6;
  localparam int FastWordsDef = 6;

  // Bytes of magic at the start of every frame header.
  localparam int MagicLen = 4;

  localparam logic [15:0] SlowTimeoutRst = 16'd500;
  localparam logic [15:0] FastTimeoutRst = 16'd100;

  typedef enum logic [2:0] {
    MODE_BYTE    = 3'd0,
    MODE_RD_SLOW = 3'd1,
    MODE_RD_FLAG = 3'd2,
    MODE_RD_FAST = 3'd3,
    MODE_TICK    = 3'd4
  } mode_e;

  // Strobes from the frame tracker to the parameter store and age counters.
  typedef struct packed {
    logic slow_word_we;
    logic fast_word_we;
    logic flag_we;
    logic slow_commit;
    logic fast_commit;
  } stage_ctl_t;

  // One bit for each frame kind.
  typedef struct packed {
    logic slow;
    logic fast;
  } kind_pair_t;

endpackage

@@ design/dmpd_frame.sv @@
// Magic-word hunter and frame byte router: window, byte counter, word assembly.
module dmpd_frame import dmpd_pkg::*; #(
  parameter int HEADER_LEN      = HeaderLenDef,
  parameter int SLOW_WORDS      = SlowWordsDef,
  parameter int SLOW_FLAG_COUNT = SlowFlagsDef,
  parameter int FAST_WORDS      = FastWordsDef,
  parameter int CNT_W           = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_en_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [31:0]      slow_magic_i,
  input  logic [31:0]      fast_magic_i,
  output stage_ctl_t       ctl_o,
  output logic [CNT_W-1:0] wr_idx_o,
  output logic [31:0]      wr_word_o
);

  localparam int SkipLen  = HEADER_LEN - MagicLen;
  localparam int SlowBody = SkipLen + 4 * SLOW_WORDS + SLOW_FLAG_COUNT;
  localparam int FastBody = SkipLen + 4 * FAST_WORDS;

  typedef enum logic [2:0] {
    KIND_HUNT = 3'b001,
    KIND_SLOW = 3'b010,
    KIND_FAST = 3'b100
  } kind_e;

  kind_e            kind_q, kind_d;
  logic [31:0]      window_q, window_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [23:0]      asm_q, asm_d;

  logic [CNT_W-1:0] cnt_fill;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] flag_pos;
  logic [CNT_W-1:0] words_len;
  logic             past_skip;
  logic             in_words;
  logic             in_flags;
  logic             commit;

  always_comb begin
    kind_d    = kind_q;
    window_d  = window_q;
    count_d   = count_q;
    asm_d     = asm_q;
    ctl_o     = '0;
    wr_idx_o  = '0;
    wr_word_o = {rx_byte_i, asm_q};
    commit    = 1'b0;

    cnt_fill  = (count_q < CNT_W'(MagicLen)) ? count_q + CNT_W'(1) : count_q;
    pos       = count_q - CNT_W'(SkipLen);
    flag_pos  = pos - CNT_W'(4 * SLOW_WORDS);
    words_len = (kind_q == KIND_SLOW) ? CNT_W'(4 * SLOW_WORDS) : CNT_W'(4 * FAST_WORDS);
    past_skip = count_q >= CNT_W'(SkipLen);
    in_words  = past_skip && (pos < words_len);
    in_flags  = (kind_q == KIND_SLOW) && past_skip && !in_words &&
                (flag_pos < CNT_W'(SLOW_FLAG_COUNT));

    if (byte_en_i) begin
      unique case (kind_q) inside
        KIND_HUNT: begin
          window_d = {rx_byte_i, window_q[31:8]};
          count_d  = cnt_fill;
          // slow magic wins when both match
          if (cnt_fill >= CNT_W'(MagicLen)) begin
            if (window_d == slow_magic_i) begin
              kind_d  = KIND_SLOW;
              count_d = '0;
            end else if (window_d == fast_magic_i) begin
              kind_d  = KIND_FAST;
              count_d = '0;
            end
          end
        end
        KIND_SLOW, KIND_FAST: begin
          count_d = count_q + CNT_W'(1);
          if (in_words) begin
            case (pos[1:0])
              2'd0: asm_d[7:0]   = rx_byte_i;
              2'd1: asm_d[15:8]  = rx_byte_i;
              2'd2: asm_d[23:16] = rx_byte_i;
              default: begin
                ctl_o.slow_word_we = (kind_q == KIND_SLOW);
                ctl_o.fast_word_we = (kind_q == KIND_FAST);
                wr_idx_o           = pos >> 2;
              end
            endcase
          end else if (in_flags) begin
            ctl_o.flag_we = 1'b1;
            wr_idx_o      = flag_pos;
          end
          ctl_o.slow_commit = (kind_q == KIND_SLOW) && (count_q == CNT_W'(SlowBody - 1));
          ctl_o.fast_commit = (kind_q == KIND_FAST) && (count_q == CNT_W'(FastBody - 1));
          commit = ctl_o.slow_commit || ctl_o.fast_commit;
          // back to hunting with an empty window
          if (commit) begin
            kind_d   = KIND_HUNT;
            count_d  = '0;
            window_d = '0;
          end
        end
        default: begin
          kind_d = KIND_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= KIND_HUNT;
      window_q <= '0;
      count_q  <= '0;
    end else begin
      kind_q   <= kind_d;
      window_q <= window_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
  end

endmodule

@@ design/dmpd_store.sv @@
// Ping-pong parameter memories, flag registers and registered read port.
module dmpd_store import dmpd_pkg::*; #(
  parameter int SLOW_WORDS      = SlowWordsDef,
  parameter int SLOW_FLAG_COUNT = SlowFlagsDef,
  parameter int FAST_WORDS      = FastWordsDef,
  parameter int CNT_W           = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stage_ctl_t       ctl_i,
  input  logic [CNT_W-1:0] wr_idx_i,
  input  logic [31:0]      wr_word_i,
  input  logic             rd_en_i,
  input  mode_e            rd_mode_i,
  input  logic [7:0]       rd_idx_i,
  input  kind_pair_t       seen_i,
  output logic [31:0]      read_data_o
);

  localparam int SlowAw = $clog2(2 * SLOW_WORDS);
  localparam int FastAw = $clog2(2 * FAST_WORDS);
  localparam int FlagN  = (SLOW_FLAG_COUNT > 0) ? SLOW_FLAG_COUNT : 1;
  localparam int FlagAw = (FlagN > 1) ? $clog2(FlagN) : 1;

  // Each bank holds a whole frame; the new frame fills the idle bank.
  logic [31:0] slow_mem [2 * SLOW_WORDS];
  logic [31:0] fast_mem [2 * FAST_WORDS];

  logic slow_bank_q;
  logic fast_bank_q;

  logic [FlagN-1:0] stage_flags_q, stage_flags_d;
  logic [FlagN-1:0] slow_flags_q;

  logic [SlowAw-1:0] slow_waddr, slow_raddr;
  logic [FastAw-1:0] fast_waddr, fast_raddr;

  logic        hit;
  logic        hit_q;
  mode_e       src_q;
  logic [31:0] slow_rd_q;
  logic [31:0] fast_rd_q;
  logic        flag_rd_q;

  assign slow_waddr = (slow_bank_q ? SlowAw'(0) : SlowAw'(SLOW_WORDS)) + SlowAw'(wr_idx_i);
  assign slow_raddr = (slow_bank_q ? SlowAw'(SLOW_WORDS) : SlowAw'(0)) + SlowAw'(rd_idx_i);
  assign fast_waddr = (fast_bank_q ? FastAw'(0) : FastAw'(FAST_WORDS)) + FastAw'(wr_idx_i);
  assign fast_raddr = (fast_bank_q ? FastAw'(FAST_WORDS) : FastAw'(0)) + FastAw'(rd_idx_i);

  // The received byte rides in the top byte of the write word.
  always_comb begin
    stage_flags_d = stage_flags_q;
    if (ctl_i.flag_we) begin
      stage_flags_d[FlagAw'(wr_idx_i)] = |wr_word_i[31:24];
    end
  end

  always_comb begin
    unique case (rd_mode_i)
      MODE_RD_SLOW: hit = (rd_idx_i < 8'(SLOW_WORDS)) && seen_i.slow;
      MODE_RD_FLAG: hit = (rd_idx_i < 8'(SLOW_FLAG_COUNT));
      MODE_RD_FAST: hit = (rd_idx_i < 8'(FAST_WORDS)) && seen_i.fast;
      default:      hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.slow_word_we) begin
      slow_mem[slow_waddr] <= wr_word_i;
    end
    if (rd_en_i && hit && (rd_mode_i == MODE_RD_SLOW)) begin
      slow_rd_q <= slow_mem[slow_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fast_word_we) begin
      fast_mem[fast_waddr] <= wr_word_i;
    end
    if (rd_en_i && hit && (rd_mode_i == MODE_RD_FAST)) begin
      fast_rd_q <= fast_mem[fast_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    stage_flags_q <= stage_flags_d;
    if (rd_en_i) begin
      hit_q     <= hit;
      src_q     <= rd_mode_i;
      flag_rd_q <= slow_flags_q[FlagAw'(rd_idx_i)];
    end
  end

  // Commit: swap the bank and, on a slow commit, take the staged flags at the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_bank_q  <= 1'b0;
      fast_bank_q  <= 1'b0;
      slow_flags_q <= '0;
    end else begin
      if (ctl_i.slow_commit) begin
        slow_bank_q  <= !slow_bank_q;
        slow_flags_q <= stage_flags_d;
      end
      if (ctl_i.fast_commit) begin
        fast_bank_q <= !fast_bank_q;
      end
    end
  end

  always_comb begin
    read_data_o = '0;
    if (hit_q) begin
      case (src_q)
        MODE_RD_SLOW: read_data_o = slow_rd_q;
        MODE_RD_FLAG: read_data_o = {31'b0, flag_rd_q};
        MODE_RD_FAST: read_data_o = fast_rd_q;
        default:      read_data_o = '0;
      endcase
    end
  end

endmodule

@@ design/dmpd_fresh.sv @@
// Saturating frame age counters, seen bits and freshness compare.
module dmpd_fresh import dmpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tick_i,
  input  stage_ctl_t  ctl_i,
  input  logic [15:0] slow_tmo_i,
  input  logic [15:0] fast_tmo_i,
  output kind_pair_t  seen_o,
  output kind_pair_t  fresh_o
);

  logic [15:0] slow_age_q, slow_age_d;
  logic [15:0] fast_age_q, fast_age_d;
  kind_pair_t  seen_q, seen_d;

  always_comb begin
    slow_age_d = slow_age_q;
    fast_age_d = fast_age_q;
    seen_d     = seen_q;
    if (tick_i) begin
      // hold at the maximum
      if (slow_age_q != '1) slow_age_d = slow_age_q + 16'd1;
      if (fast_age_q != '1) fast_age_d = fast_age_q + 16'd1;
    end
    if (ctl_i.slow_commit) begin
      slow_age_d  = '0;
      seen_d.slow = 1'b1;
    end
    if (ctl_i.fast_commit) begin
      fast_age_d  = '0;
      seen_d.fast = 1'b1;
    end
  end

  assign fresh_o.slow = seen_d.slow && (slow_age_d < slow_tmo_i);
  assign fresh_o.fast = seen_d.fast && (fast_age_d < fast_tmo_i);
  assign seen_o       = seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_age_q <= '0;
      fast_age_q <= '0;
      seen_q     <= '0;
    end else begin
      slow_age_q <= slow_age_d;
      fast_age_q <= fast_age_d;
      seen_q     <= seen_d;
    end
  end

endmodule

@@ design/dual_magic_param_deframer.sv @@
// Top level: input register, config registers, frame tracker, store, ages, result register.
// An input transfer reaches its result through the input register, then the
// result register with the registered memory read.
// Throughput: one item per cycle, set by the input-to-result register pair; a
// stalled result holds while one more item waits in the input register.
// Reset: asynchronous, active low; clears handshake state, frame tracker, ages
// and bank selects, and sets config to its defaults. No clearing pass: stores read 0 until committed.
module dual_magic_param_deframer import dmpd_pkg::*; #(
  parameter int HEADER_LEN      = HeaderLenDef,
  parameter int SLOW_WORDS      = SlowWordsDef,
  parameter int SLOW_FLAG_COUNT = SlowFlagsDef,
  parameter int FAST_WORDS      = FastWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], index[15:8]
  input  logic [2:0]  s_axis_tuser,   // mode[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_data[31:0], frame_done[33:32],
                                      // slow_fresh[34], fast_fresh[35], zero[39:36]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int SkipLen  = HEADER_LEN - MagicLen;
  localparam int SlowBody = SkipLen + 4 * SLOW_WORDS + SLOW_FLAG_COUNT;
  localparam int FastBody = SkipLen + 4 * FAST_WORDS;
  localparam int StageLen = (SlowBody > FastBody) ? SlowBody : FastBody;
  localparam int CntW     = $clog2(StageLen + 1);

  typedef enum logic [1:0] {
    CFG_SLOW_MAGIC = 2'd0,
    CFG_FAST_MAGIC = 2'd1,
    CFG_SLOW_TMO   = 2'd2,
    CFG_FAST_TMO   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DONE_NONE = 2'd0,
    DONE_SLOW = 2'd1,
    DONE_FAST = 2'd2
  } done_e;

  logic [31:0] slow_magic_q;
  logic [31:0] fast_magic_q;
  logic [15:0] slow_tmo_q;
  logic [15:0] fast_tmo_q;

  logic       in_valid_q;
  logic [2:0] in_mode_q;
  logic [7:0] in_byte_q;
  logic [7:0] in_idx_q;

  logic       out_valid_q;
  done_e      done_q, done_d;
  kind_pair_t fresh_q;

  logic       s_xfer;
  logic       adv;
  logic       byte_en;
  logic       tick;

  stage_ctl_t       ctl;
  logic [CntW-1:0]  wr_idx;
  logic [31:0]      wr_word;
  logic [31:0]      read_data;
  kind_pair_t       seen;
  kind_pair_t       fresh;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign byte_en       = adv && (in_mode_q == MODE_BYTE);
  assign tick          = adv && (in_mode_q == MODE_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_magic_q <= '0;
      fast_magic_q <= '0;
      slow_tmo_q   <= SlowTimeoutRst;
      fast_tmo_q   <= FastTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SLOW_MAGIC: slow_magic_q <= cfg_wdata_i;
        CFG_FAST_MAGIC: fast_magic_q <= cfg_wdata_i;
        CFG_SLOW_TMO:   slow_tmo_q   <= cfg_wdata_i[15:0];
        CFG_FAST_TMO:   fast_tmo_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_mode_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata[7:0];
      in_idx_q  <= s_axis_tdata[15:8];
    end
    if (adv) begin
      done_q  <= done_d;
      fresh_q <= fresh;
    end
  end

  always_comb begin
    if (ctl.slow_commit) begin
      done_d = DONE_SLOW;
    end else if (ctl.fast_commit) begin
      done_d = DONE_FAST;
    end else begin
      done_d = DONE_NONE;
    end
  end

  dmpd_frame #(
    .HEADER_LEN      (HEADER_LEN),
    .SLOW_WORDS      (SLOW_WORDS),
    .SLOW_FLAG_COUNT (SLOW_FLAG_COUNT),
    .FAST_WORDS      (FAST_WORDS),
    .CNT_W           (CntW)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (byte_en),
    .rx_byte_i    (in_byte_q),
    .slow_magic_i (slow_magic_q),
    .fast_magic_i (fast_magic_q),
    .ctl_o        (ctl),
    .wr_idx_o     (wr_idx),
    .wr_word_o    (wr_word)
  );

  dmpd_store #(
    .SLOW_WORDS      (SLOW_WORDS),
    .SLOW_FLAG_COUNT (SLOW_FLAG_COUNT),
    .FAST_WORDS      (FAST_WORDS),
    .CNT_W           (CntW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .wr_idx_i    (wr_idx),
    .wr_word_i   (wr_word),
    .rd_en_i     (adv),
    .rd_mode_i   (mode_e'(in_mode_q)),
    .rd_idx_i    (in_idx_q),
    .seen_i      (seen),
    .read_data_o (read_data)
  );

  dmpd_fresh u_fresh (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .ctl_i      (ctl),
    .slow_tmo_i (slow_tmo_q),
    .fast_tmo_i (fast_tmo_q),
    .seen_o     (seen),
    .fresh_o    (fresh)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, fresh_q.fast, fresh_q.slow, done_q, read_data};

endmodule

@@ design/dmpd_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
module dmpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // With the result side empty the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // Frame done has only three codes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[33:32] != 2'b11)
    else $error("bad frame done code");

  // A commit comes from a received byte, never from a read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] != 2'b00) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("commit result carries read data");

endmodule

bind dual_magic_param_deframer dmpd_checker u_dmpd_checker (.*);

@@ tb/sv/dmpd_tb_pkg.sv @@
// Testbench constants: register indexes, frame-done codes and frame sizes of the deframer.
package dmpd_tb_pkg;

  typedef enum logic [1:0] {
    REG_SLOW_MAGIC   = 2'd0,
    REG_FAST_MAGIC   = 2'd1,
    REG_SLOW_TIMEOUT = 2'd2,
    REG_FAST_TIMEOUT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    DONE_NONE = 2'd0,
    DONE_SLOW = 2'd1,
    DONE_FAST = 2'd2
  } frame_done_e;

  // Bytes after the magic: skipped header bytes, then the payload.
  localparam int SkipLen  = dmpd_pkg::HeaderLenDef - dmpd_pkg::MagicLen;
  localparam int SlowBody = SkipLen + 4 * dmpd_pkg::SlowWordsDef + dmpd_pkg::SlowFlagsDef;
  localparam int FastBody = SkipLen + 4 * dmpd_pkg::FastWordsDef;
  localparam int StageLen = (SlowBody > FastBody) ? SlowBody : FastBody;

  localparam logic [15:0] AgeMax = 16'hFFFF;

endpackage

@@ tb/sv/param_deframer_check.sv @@
// Checker: predicts each result of the deframer from accepted transfers and compares them.
module param_deframer_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // rx_byte[7:0], index[15:8]
  input  logic [2:0]  s_axis_tuser,   // mode[2:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // read_data[31:0], frame_done[33:32],
                                      // slow_fresh[34], fast_fresh[35], zero[39:36]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dmpd_pkg::*;
  import dmpd_tb_pkg::*;

  typedef enum logic [1:0] {
    HUNTING = 2'd0,
    IN_SLOW = 2'd1,
    IN_FAST = 2'd2
  } frame_kind_e;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  frame_done;
    logic        slow_fresh;
    logic        fast_fresh;
  } frame_result_t;

  logic [31:0] slow_magic;
  logic [31:0] fast_magic;
  logic [15:0] slow_timeout;
  logic [15:0] fast_timeout;

  logic [31:0] sync_window;
  int          frame_bytes;
  frame_kind_e frame_kind;
  logic [7:0]  staged [StageLen];
  logic [31:0] slow_words [SlowWordsDef];
  logic        slow_flags [SlowFlagsDef];
  logic [31:0] fast_words [FastWordsDef];
  logic [15:0] slow_age;
  logic [15:0] fast_age;
  logic        slow_seen;
  logic        fast_seen;

  frame_result_t expected_results [$];
  frame_result_t oldest;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_cnt_o++;
  endtask

  function automatic logic [31:0] staged_word(int pos);
    return {staged[pos + 3], staged[pos + 2], staged[pos + 1], staged[pos]};
  endfunction

  // Shift a byte through the magic hunter, or stage it and commit a complete frame.
  function automatic frame_done_e take_byte(logic [7:0] b);
    frame_done_e done;
    int          i;
    done = DONE_NONE;
    if (frame_kind == HUNTING) begin
      sync_window = {b, sync_window[31:8]};
      if (frame_bytes < MagicLen) frame_bytes++;
      if (frame_bytes >= MagicLen) begin
        if (sync_window == slow_magic) begin
          frame_kind  = IN_SLOW;
          frame_bytes = 0;
        end else if (sync_window == fast_magic) begin
          frame_kind  = IN_FAST;
          frame_bytes = 0;
        end
      end
      return DONE_NONE;
    end
    if (frame_bytes < StageLen) staged[frame_bytes] = b;
    frame_bytes++;
    if (frame_kind == IN_SLOW && frame_bytes >= SlowBody) begin
      for (i = 0; i < SlowWordsDef; i++) slow_words[i] = staged_word(SkipLen + 4 * i);
      for (i = 0; i < SlowFlagsDef; i++)
        slow_flags[i] = (staged[SkipLen + 4 * SlowWordsDef + i] != 8'h00);
      slow_age  = '0;
      slow_seen = 1'b1;
      done      = DONE_SLOW;
    end else if (frame_kind == IN_FAST && frame_bytes >= FastBody) begin
      for (i = 0; i < FastWordsDef; i++) fast_words[i] = staged_word(SkipLen + 4 * i);
      fast_age  = '0;
      fast_seen = 1'b1;
      done      = DONE_FAST;
    end
    if (done != DONE_NONE) begin
      frame_kind  = HUNTING;
      frame_bytes = 0;
      sync_window = '0;
    end
    return done;
  endfunction

  function automatic frame_result_t deframe_item(logic [2:0] mode, logic [7:0] rx_byte,
                                                 logic [7:0] idx);
    frame_result_t res;
    res = '0;
    case (mode)
      MODE_BYTE:    res.frame_done = take_byte(rx_byte);
      MODE_RD_SLOW: if (idx < SlowWordsDef) res.read_data = slow_words[idx];
      MODE_RD_FLAG: if (idx < SlowFlagsDef) res.read_data = {31'd0, slow_flags[idx]};
      MODE_RD_FAST: if (idx < FastWordsDef) res.read_data = fast_words[idx];
      MODE_TICK: begin
        if (slow_age != AgeMax) slow_age++;
        if (fast_age != AgeMax) fast_age++;
      end
      default: ;
    endcase
    res.slow_fresh = slow_seen && (slow_age < slow_timeout);
    res.fast_fresh = fast_seen && (fast_age < fast_timeout);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_magic   = '0;
      fast_magic   = '0;
      slow_timeout = SlowTimeoutRst;
      fast_timeout = FastTimeoutRst;
      sync_window  = '0;
      frame_bytes  = 0;
      frame_kind   = HUNTING;
      foreach (slow_words[i]) slow_words[i] = '0;
      foreach (slow_flags[i]) slow_flags[i] = 1'b0;
      foreach (fast_words[i]) fast_words[i] = '0;
      slow_age     = '0;
      fast_age     = '0;
      slow_seen    = 1'b0;
      fast_seen    = 1'b0;
      expected_results.delete();
      fail_cnt_o   = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          oldest = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== oldest.read_data)
            report_mismatch("read_data", m_axis_tdata[31:0], oldest.read_data);
          if (m_axis_tdata[33:32] !== oldest.frame_done)
            report_mismatch("frame_done", 32'(m_axis_tdata[33:32]), 32'(oldest.frame_done));
          if (m_axis_tdata[34] !== oldest.slow_fresh)
            report_mismatch("slow_fresh", 32'(m_axis_tdata[34]), 32'(oldest.slow_fresh));
          if (m_axis_tdata[35] !== oldest.fast_fresh)
            report_mismatch("fast_fresh", 32'(m_axis_tdata[35]), 32'(oldest.fast_fresh));
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SLOW_MAGIC:   slow_magic   = cfg_wdata_i;
          REG_FAST_MAGIC:   fast_magic   = cfg_wdata_i;
          REG_SLOW_TIMEOUT: slow_timeout = cfg_wdata_i[15:0];
          REG_FAST_TIMEOUT: fast_timeout = cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(deframe_item(s_axis_tuser, s_axis_tdata[7:0],
                                                s_axis_tdata[15:8]));
      pending_o = expected_results.size();
    end
  end

endmodule

@@ tb/sv/tb_dual_magic_param_deframer.sv @@
// Testbench top: clock, reset, config writes, item stimulus and verdict for the deframer.
module tb_dual_magic_param_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import dmpd_pkg::*;
  import dmpd_tb_pkg::*;

  localparam logic [2:0] ModeMax = 3'd7;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_idx       = '0;
  logic [31:0] cfg_wdata     = '0;

  int          fail_cnt;
  int          pending_cnt;
  int          items_sent    = 0;
  bit          send_gaps     = 1'b1;
  bit          rx_stalls     = 1'b1;
  logic [31:0] cur_slow_magic = '0;
  logic [31:0] cur_fast_magic = '0;

  always #2 clk = ~clk;

  dual_magic_param_deframer uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  param_deframer_check param_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt)
  );

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly none, sometimes a few cycles, rarely a long stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : sink_ready
    int stall;
    int run;
    forever begin
      stall = rx_stalls ? idle_len() : 0;
      run   = $urandom_range(1, 12);
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
      end
      repeat (run) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [2:0] mode, logic [7:0] rx_byte, logic [7:0] idx);
    int gap;
    gap = send_gaps ? idle_len() : 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {idx, rx_byte};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(MODE_BYTE, b, 8'($urandom()));
  endtask

  task automatic send_tick();
    send_item(MODE_TICK, 8'($urandom()), 8'($urandom()));
  endtask

  task automatic send_read();
    logic [2:0] mode;
    int         lim;
    logic [7:0] idx;
    case ($urandom_range(0, 2))
      0: begin mode = MODE_RD_SLOW; lim = SlowWordsDef; end
      1: begin mode = MODE_RD_FLAG; lim = SlowFlagsDef; end
      default: begin mode = MODE_RD_FAST; lim = FastWordsDef; end
    endcase
    idx = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, lim - 1)) : 8'($urandom());
    send_item(mode, 8'($urandom()), idx);
  endtask

  // Magic, then the body; reads and ticks slip in between bytes now and then.
  task automatic send_frame(bit slow_kind);
    logic [31:0] magic;
    int          body;
    int          style;
    int          k;
    logic [7:0]  b;
    magic = slow_kind ? cur_slow_magic : cur_fast_magic;
    body  = slow_kind ? SlowBody : FastBody;
    style = $urandom_range(0, 3);
    for (k = 0; k < MagicLen; k++) send_byte(magic[8 * k +: 8]);
    for (k = 0; k < body; k++) begin
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 9) < 6) send_read();
        else send_tick();
      end
      case (style)
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom());
      endcase
      if (slow_kind && k >= body - SlowFlagsDef && $urandom_range(0, 1) == 0) b = 8'h00;
      send_byte(b);
    end
  endtask

  task automatic random_traffic(int n);
    int          stop_at;
    int          r;
    int          k;
    int          len;
    logic [31:0] magic;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        send_frame(1'b0);
      end else if (r < 50) begin
        len = $urandom_range(1, 6);
        repeat (len) send_byte(8'($urandom()));
      end else if (r < 60) begin
        // broken magic: a prefix, then a random byte
        magic = $urandom_range(0, 1) ? cur_slow_magic : cur_fast_magic;
        len   = $urandom_range(1, MagicLen - 1);
        for (k = 0; k < len; k++) send_byte(magic[8 * k +: 8]);
        send_byte(8'($urandom()));
      end else if (r < 80) begin
        repeat ($urandom_range(1, 6)) send_read();
      end else if (r < 95) begin
        repeat ($urandom_range(1, 20)) send_tick();
      end else begin
        send_item(3'($urandom_range(int'(MODE_TICK) + 1, int'(ModeMax))), 8'($urandom()),
                  8'($urandom()));
      end
    end
  endtask

  // Hold off the sender until every result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_cnt != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] slow_m, logic [31:0] fast_m,
                              logic [15:0] slow_t, logic [15:0] fast_t);
    write_reg(REG_SLOW_MAGIC, slow_m);
    write_reg(REG_FAST_MAGIC, fast_m);
    write_reg(REG_SLOW_TIMEOUT, {16'd0, slow_t});
    write_reg(REG_FAST_TIMEOUT, {16'd0, fast_t});
    cfg_we         <= 1'b0;
    cur_slow_magic  = slow_m;
    cur_fast_magic  = fast_m;
  endtask

  function automatic logic [31:0] pick_magic();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [15:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd1;
    if (r < 25) return 16'hFFFF;
    if (r < 30) return 16'd0;
    return 16'($urandom_range(1, 60));
  endfunction

  initial begin : stimulus
    logic [31:0] shared_magic;
    int          ph;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing committed yet: every read returns zero, out-of-range indexes too.
    send_item(MODE_RD_SLOW, 8'h00, 8'h00);
    send_item(MODE_RD_SLOW, 8'hFF, 8'(SlowWordsDef - 1));
    send_item(MODE_RD_SLOW, 8'h00, 8'(SlowWordsDef));
    send_item(MODE_RD_SLOW, 8'hFF, 8'hFF);
    send_item(MODE_RD_FLAG, 8'h00, 8'h00);
    send_item(MODE_RD_FLAG, 8'hFF, 8'(SlowFlagsDef - 1));
    send_item(MODE_RD_FLAG, 8'h00, 8'(SlowFlagsDef));
    send_item(MODE_RD_FAST, 8'hFF, 8'h00);
    send_item(MODE_RD_FAST, 8'h00, 8'(FastWordsDef - 1));
    send_item(MODE_RD_FAST, 8'hFF, 8'(FastWordsDef));
    send_item(MODE_RD_FAST, 8'h00, 8'hFF);
    send_item(MODE_TICK, 8'hFF, 8'hFF);
    send_item(3'(int'(MODE_TICK) + 1), 8'hFF, 8'hFF);
    send_item(ModeMax, 8'h00, 8'h00);
    // Both magics are zero here: three zero bytes must not start a frame.
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);

    // Shortest timeouts: fresh only until the first tick after a commit.
    drain_results();
    write_config(pick_magic(), $urandom(), 16'd1, 16'd1);
    send_frame(1'b1);
    random_traffic(60);

    // Equal magics: the slow frame wins.
    drain_results();
    shared_magic = $urandom();
    write_config(shared_magic, shared_magic, 16'hFFFF, 16'hFFFF);
    send_frame(1'b1);
    send_frame(1'b0);
    random_traffic(100);

    // Zero timeouts never report fresh; a zero fast magic needs a full window.
    drain_results();
    write_config($urandom(), 32'h0000_0000, 16'd0, 16'd0);
    send_frame(1'b0);
    random_traffic(80);

    for (ph = 0; ph < 5; ph++) begin
      drain_results();
      send_gaps = (ph != 2);
      rx_stalls = (ph != 3);
      write_config(pick_magic(), pick_magic(), pick_timeout(), pick_timeout());
      if (ph == 2) send_frame(1'b1);
      random_traffic(70);
    end

    drain_results();
    send_gaps = 1'b1;
    rx_stalls = 1'b1;
    write_config(32'hFFFF_FFFF, pick_magic(), 16'd1, 16'hFFFF);
    send_frame(1'b1);
    random_traffic(50);

    drain_results();
    @(negedge clk);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
